// ----- design/at_command_parser_macros.svh -----
// assertion macros for the at command parser
// expects clk and arst_n in the scope of each use
`ifndef AT_COMMAND_PARSER_MACROS_SVH
`define AT_COMMAND_PARSER_MACROS_SVH

// same-cycle implication, checked out of reset
`define ATCP_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ATCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/atcp_pkg.sv -----
// shared types and constants for the at command parser
// no dependencies
`timescale 1ns / 1ps

package atcp_pkg;

	// command buffer size and counter widths
	localparam int BUF_BYTES = 64;
	localparam int FILL_W    = 7;
	localparam int INDEX_W   = 6;
	localparam int COUNT_W   = 5;
	localparam logic [COUNT_W-1:0] TOKEN_MAX = 5'd31;

	// body positions of interest
	localparam logic [FILL_W-1:0] POS_LETTER_ONE = 7'd3;
	localparam logic [FILL_W-1:0] POS_LETTER_TWO = 7'd4;
	localparam logic [FILL_W-1:0] POS_SIXTH      = 7'd5;

	// characters
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNKNOWN  = 2'd1,
		ST_PARAM    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_SEMI  = 2'd1,
		KIND_EQ    = 2'd2,
		KIND_OTHER = 2'd3
	} sixth_kind_t;

	// collection state, all zero when empty
	typedef struct packed {
		logic                collecting;
		logic [FILL_W-1:0]   fill_count;
		logic                first_is_a;
		logic                second_is_t;
		logic                prefix_exact;
		logic [7:0]          letter_one;
		logic [7:0]          letter_two;
		sixth_kind_t         sixth_kind;
		logic                inside_token;
		logic [COUNT_W-1:0]  token_total;
	} parser_state_t;

	// lookup result from the command table
	typedef struct packed {
		logic               hit;
		logic [INDEX_W-1:0] index;
	} cmd_lookup_t;

endpackage

// ----- design/at_command_parser.sv -----
// at command parser top level: stream in bytes, one status result per command
// depends on atcp_pkg, atcp_cmd_table and at_command_parser_macros.svh
// a ';' byte accepted at s_tdata passes through the input register and then the result register to m_tvalid
// throughput: one byte per cycle; the input register and result register overlap
// a byte waits in the input register only while a finished result is not yet taken
// reset: arst_n clears the collection state and both valid flags, no result pending
`timescale 1ns / 1ps
`include "at_command_parser_macros.svh"

module at_command_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [1:0] result_status, [7:2] command_index,
	                               // [12:8] param_count, [15:13] zero
);

	logic                     valid_s1;
	logic [7:0]               rx_s1;
	atcp_pkg::parser_state_t  state_q;
	atcp_pkg::parser_state_t  state_nxt;
	atcp_pkg::cmd_lookup_t    lookup;
	logic                     out_free;
	logic                     advance;
	logic                     full;
	logic                     emit;
	atcp_pkg::status_t        res_status;
	logic [atcp_pkg::INDEX_W-1:0] res_index;
	logic [atcp_pkg::COUNT_W-1:0] res_count;
	logic                     m_valid_q;
	logic [15:0]              m_data_q;

	// handshake: the input register moves on whenever the result slot is free
	assign out_free = !m_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign full     = state_q.fill_count >= atcp_pkg::FILL_W'(atcp_pkg::BUF_BYTES);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rx_s1 <= s_tdata;
		end
	end

	// name lookup on the stored letters
	atcp_cmd_table u_cmd_table (
		.letter_one (state_q.letter_one),
		.letter_two (state_q.letter_two),
		.lookup     (lookup)
	);

	// per-byte state update and result
	always_comb begin
		state_nxt  = state_q;
		emit       = 1'b0;
		res_status = atcp_pkg::ST_OK;
		res_index  = '0;
		res_count  = '0;
		if (!state_q.collecting) begin
			// prefix stage
			case (rx_s1)
				atcp_pkg::CH_A: begin
					if (full) begin
						state_nxt = '0;
					end else begin
						if (state_q.fill_count == 7'd0) state_nxt.first_is_a = 1'b1;
						if (state_q.fill_count == 7'd1) state_nxt.second_is_t = 1'b0;
						state_nxt.fill_count = state_q.fill_count + 7'd1;
					end
				end
				atcp_pkg::CH_T: begin
					if (!state_q.first_is_a || full) begin
						state_nxt = '0;
					end else begin
						if (state_q.fill_count == 7'd1) state_nxt.second_is_t = 1'b1;
						state_nxt.fill_count = state_q.fill_count + 7'd1;
					end
				end
				atcp_pkg::CH_PLUS: begin
					if (!state_q.second_is_t || full) begin
						state_nxt = '0;
					end else begin
						state_nxt.prefix_exact = (state_q.fill_count == 7'd2);
						state_nxt.fill_count   = state_q.fill_count + 7'd1;
						state_nxt.collecting   = 1'b1;
					end
				end
				default: state_nxt = '0;
			endcase
		end else if (rx_s1 == atcp_pkg::CH_NUL || rx_s1 == atcp_pkg::CH_LF) begin
			// skipped in the body
		end else if (full) begin
			// buffer full: only ';' ends the command, as overflow
			if (rx_s1 == atcp_pkg::CH_SEMI) begin
				emit       = 1'b1;
				res_status = atcp_pkg::ST_OVERFLOW;
				state_nxt  = '0;
			end
		end else begin
			// place the byte at its position
			if (state_q.fill_count == atcp_pkg::POS_LETTER_ONE) begin
				state_nxt.letter_one = rx_s1;
			end else if (state_q.fill_count == atcp_pkg::POS_LETTER_TWO) begin
				state_nxt.letter_two = rx_s1;
			end else if (state_q.fill_count == atcp_pkg::POS_SIXTH) begin
				if (rx_s1 == atcp_pkg::CH_SEMI) begin
					state_nxt.sixth_kind = atcp_pkg::KIND_SEMI;
				end else if (rx_s1 == atcp_pkg::CH_EQ) begin
					state_nxt.sixth_kind = atcp_pkg::KIND_EQ;
				end else begin
					state_nxt.sixth_kind = atcp_pkg::KIND_OTHER;
				end
			end else if (state_q.fill_count > atcp_pkg::POS_SIXTH) begin
				if (rx_s1 == atcp_pkg::CH_COMMA) begin
					state_nxt.inside_token = 1'b0;
				end else if (!state_q.inside_token) begin
					state_nxt.inside_token = 1'b1;
					if (state_q.token_total != atcp_pkg::TOKEN_MAX) begin
						state_nxt.token_total = state_q.token_total + 5'd1;
					end
				end
			end
			state_nxt.fill_count = state_q.fill_count + 7'd1;

			// ';' closes the command; a ';' in a letter slot never names a command
			if (rx_s1 == atcp_pkg::CH_SEMI) begin
				emit = 1'b1;
				if (state_q.prefix_exact && lookup.hit &&
				    state_q.fill_count >= atcp_pkg::POS_SIXTH) begin
					if (state_q.fill_count == atcp_pkg::POS_SIXTH) begin
						res_index = lookup.index;
					end else if (state_q.sixth_kind == atcp_pkg::KIND_EQ) begin
						res_index = lookup.index;
						res_count = state_nxt.token_total;
					end else begin
						res_status = atcp_pkg::ST_PARAM;
					end
				end else begin
					res_status = atcp_pkg::ST_UNKNOWN;
				end
				state_nxt = '0;
			end
		end
	end

	// collection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			m_data_q <= {3'b000, res_count, res_index, res_status};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// checks
	`ATCP_ASSERT_IMPLY(a_collect_fill, state_q.collecting, state_q.fill_count >= 7'd3, "body running with short prefix")
	`ATCP_ASSERT_IMPLY(a_fill_bound, 1'b1, state_q.fill_count <= atcp_pkg::FILL_W'(atcp_pkg::BUF_BYTES), "fill count past buffer size")
	`ATCP_ASSERT_IMPLY(a_idle_clean, !state_q.collecting, state_q.token_total == 5'd0 && state_q.sixth_kind == atcp_pkg::KIND_NONE, "body state left over in prefix stage")
	`ATCP_ASSERT_IMPLY(a_fail_zero, m_tvalid && m_tdata[1:0] != atcp_pkg::ST_OK, m_tdata[12:2] == 11'd0, "failed result with nonzero index or count")
	`ATCP_ASSERT_NEXT(a_result_from_semi, !m_tvalid && m_valid_q == 1'b0 && !(advance && emit), !m_tvalid, "result without a closing byte")

endmodule

// ----- design/atcp_cmd_table.sv -----
// two-letter command name table, case sensitive, 38 entries
// depends on atcp_pkg
`timescale 1ns / 1ps

module atcp_cmd_table (
	input  logic [7:0]             letter_one,
	input  logic [7:0]             letter_two,
	output atcp_pkg::cmd_lookup_t  lookup
);

	// decode the name pair to its table position
	always_comb begin
		lookup.hit   = 1'b1;
		lookup.index = '0;
		unique case ({letter_one, letter_two})
			"SD": lookup.index = 6'd0;
			"II": lookup.index = 6'd1;
			"GX": lookup.index = 6'd2;
			"GY": lookup.index = 6'd3;
			"DO": lookup.index = 6'd4;
			"DF": lookup.index = 6'd5;
			"SC": lookup.index = 6'd6;
			"SB": lookup.index = 6'd7;
			"SP": lookup.index = 6'd8;
			"WP": lookup.index = 6'd9;
			"cs": lookup.index = 6'd10;
			"fs": lookup.index = 6'd11;
			"sf": lookup.index = 6'd12;
			"gf": lookup.index = 6'd13;
			"sb": lookup.index = 6'd14;
			"gb": lookup.index = 6'd15;
			"dp": lookup.index = 6'd16;
			"dl": lookup.index = 6'd17;
			"dr": lookup.index = 6'd18;
			"dc": lookup.index = 6'd19;
			"dR": lookup.index = 6'd20;
			"fr": lookup.index = 6'd21;
			"fc": lookup.index = 6'd22;
			"fR": lookup.index = 6'd23;
			"ps": lookup.index = 6'd24;
			"pi": lookup.index = 6'd25;
			"pf": lookup.index = 6'd26;
			"sF": lookup.index = 6'd27;
			"gF": lookup.index = 6'd28;
			"gX": lookup.index = 6'd29;
			"gY": lookup.index = 6'd30;
			"dB": lookup.index = 6'd31;
			"DT": lookup.index = 6'd32;
			"ED": lookup.index = 6'd33;
			"EW": lookup.index = 6'd34;
			"FW": lookup.index = 6'd35;
			"gt": lookup.index = 6'd36;
			"DB": lookup.index = 6'd37;
			default: lookup.hit = 1'b0;
		endcase
	end

endmodule

// ----- sim/at_command_parser_tb.sv -----
// self-checking testbench for the at command parser: directed command table, then random lines
// depends on atcp_pkg and the at_command_parser rtl; expected results come from an inline predictor
`timescale 1ns / 1ps

module at_command_parser_tb;

	// one expected or observed result request
	typedef struct packed {
		atcp_pkg::status_t            st;
		logic [atcp_pkg::INDEX_W-1:0] idx;
		logic [atcp_pkg::COUNT_W-1:0] cnt;
	} reply_t;

	// one directed command line; '~' stands for a nul byte and '^' for 0xff
	typedef struct {
		string      txt;
		int         pad;
		logic [7:0] pad_ch;
		bit         typed;
		reply_t     want;
	} line_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	// two-letter command names, first letter in the high byte
	localparam logic [15:0] CMD_NAMES [0:37] = '{
		"SD", "II", "GX", "GY", "DO", "DF", "SC", "SB", "SP", "WP",
		"cs", "fs", "sf", "gf", "sb", "gb", "dp", "dl", "dr", "dc",
		"dR", "fr", "fc", "fR", "ps", "pi", "pf", "sF", "gF", "gX",
		"gY", "dB", "DT", "ED", "EW", "FW", "gt", "DB"
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	// predictor copy of the line state
	logic                         in_body;
	logic [atcp_pkg::FILL_W-1:0]  used;
	logic                         saw_a0;
	logic                         saw_t1;
	logic                         plus_at_two;
	logic [7:0]                   name_hi;
	logic [7:0]                   name_lo;
	atcp_pkg::sixth_kind_t        kind6;
	logic                         in_token;
	logic [atcp_pkg::COUNT_W-1:0] tokens;

	reply_t exp_q[$];
	line_t  plan[$];
	bit     typed_pending;
	reply_t typed_reply;
	int     errors;
	int     bytes_in;
	int     results;
	int     per_status[4];
	int     burst_left;

	at_command_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#3_000_000;
		$display("at_command_parser_tb: done, errors");
		$finish;
	end

	// empty the predicted line
	function automatic void drop_line();
		in_body     = 1'b0;
		used        = '0;
		saw_a0      = 1'b0;
		saw_t1      = 1'b0;
		plus_at_two = 1'b0;
		name_hi     = '0;
		name_lo     = '0;
		kind6       = atcp_pkg::KIND_NONE;
		in_token    = 1'b0;
		tokens      = '0;
	endfunction

	// status of a line closed by ';' inside the buffer
	function automatic reply_t close_line();
		reply_t r;
		bit     hit;
		r   = '{atcp_pkg::ST_UNKNOWN, '0, '0};
		hit = 1'b0;
		if (plus_at_two)
			for (int k = 0; k < 38; k++)
				if (!hit && CMD_NAMES[k] == {name_hi, name_lo}) begin
					hit   = 1'b1;
					r.idx = atcp_pkg::INDEX_W'(k);
				end
		if (hit) begin
			if (kind6 == atcp_pkg::KIND_SEMI) begin
				r.st = atcp_pkg::ST_OK;
			end else if (kind6 != atcp_pkg::KIND_EQ) begin
				r.st  = atcp_pkg::ST_PARAM;
				r.idx = '0;
			end else begin
				r.st  = atcp_pkg::ST_OK;
				r.cnt = tokens;
			end
		end
		return r;
	endfunction

	// advance the predictor by one accepted byte
	task automatic parse_byte(input logic [7:0] b, output bit got, output reply_t r);
		bit full;
		got  = 1'b0;
		r    = '0;
		full = (used >= atcp_pkg::BUF_BYTES);
		if (!in_body) begin
			if (b == atcp_pkg::CH_A) begin
				if (full) begin
					drop_line();
				end else begin
					if (used == 0) saw_a0 = 1'b1;
					if (used == 1) saw_t1 = 1'b0;
					used++;
				end
			end else if (b == atcp_pkg::CH_T) begin
				if (!saw_a0 || full) begin
					drop_line();
				end else begin
					if (used == 1) saw_t1 = 1'b1;
					used++;
				end
			end else if (b == atcp_pkg::CH_PLUS) begin
				if (!saw_t1 || full) begin
					drop_line();
				end else begin
					plus_at_two = (used == 2);
					used++;
					in_body = 1'b1;
				end
			end else begin
				drop_line();
			end
		end else if (b == atcp_pkg::CH_NUL || b == atcp_pkg::CH_LF) begin
			// skipped inside the body
		end else if (full) begin
			if (b == atcp_pkg::CH_SEMI) begin
				got  = 1'b1;
				r.st = atcp_pkg::ST_OVERFLOW;
				drop_line();
			end
		end else begin
			if (used == atcp_pkg::POS_LETTER_ONE) begin
				name_hi = b;
			end else if (used == atcp_pkg::POS_LETTER_TWO) begin
				name_lo = b;
			end else if (used == atcp_pkg::POS_SIXTH) begin
				kind6 = (b == atcp_pkg::CH_SEMI) ? atcp_pkg::KIND_SEMI :
				        (b == atcp_pkg::CH_EQ)   ? atcp_pkg::KIND_EQ   :
				                                   atcp_pkg::KIND_OTHER;
			end else if (used > atcp_pkg::POS_SIXTH) begin
				if (b == atcp_pkg::CH_COMMA) begin
					in_token = 1'b0;
				end else if (!in_token) begin
					in_token = 1'b1;
					if (tokens < atcp_pkg::TOKEN_MAX) tokens++;
				end
			end
			used++;
			if (b == atcp_pkg::CH_SEMI) begin
				got = 1'b1;
				r   = close_line();
				drop_line();
			end
		end
	endtask

	// check results first, then feed accepted bytes to the predictor
	always @(posedge clk) begin
		reply_t want;
		reply_t seen;
		reply_t r;
		bit     got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results++;
				seen = '{atcp_pkg::status_t'(m_tdata[1:0]), m_tdata[7:2], m_tdata[12:8]};
				if (exp_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result request, expected none, got %h",
					         $time, m_tdata);
				end else begin
					want = exp_q.pop_front();
					per_status[want.st]++;
					if (seen.st !== want.st || seen.idx !== want.idx || seen.cnt !== want.cnt
					    || m_tdata[15:13] !== 3'b000) begin
						errors++;
						$display({"%0t: mismatch, expected status %0d index %0d count %0d,",
						          " got status %0d index %0d count %0d pad %b"},
						         $time, want.st, want.idx, want.cnt, m_tdata[1:0],
						         m_tdata[7:2], m_tdata[12:8], m_tdata[15:13]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				bytes_in++;
				parse_byte(s_tdata, got, r);
				if (got) begin
					if (typed_pending) begin
						r             = typed_reply;
						typed_pending = 1'b0;
					end
					exp_q.push_back(r);
				end
			end
		end
	end

	// receiver: changing stall patterns, plus one long hold-off early on
	initial begin
		rx_mode_t mode;
		int       span;
		int       hold;
		bit       held;
		m_tready = 1'b0;
		mode     = RX_OPEN;
		span     = 0;
		hold     = 0;
		held     = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results >= 3) begin
				held = 1'b1;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				if (span == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					span = $urandom_range(5, 60);
				end
				span--;
				case (mode)
					RX_OPEN:   m_tready <= 1'b1;
					RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// offer one byte in bursts with random gaps; called and returns at a falling edge
	task automatic push_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tdata  <= b;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic add_line(input string txt, input int pad, input logic [7:0] pad_ch,
	                        input bit typed, input atcp_pkg::status_t st, input int idx);
		line_t l;
		l.txt    = txt;
		l.pad    = pad;
		l.pad_ch = pad_ch;
		l.typed  = typed;
		l.want   = '{st, atcp_pkg::INDEX_W'(idx), '0};
		plan.push_back(l);
	endtask

	// one random parameter byte, mostly commas and printable text
	function automatic logic [7:0] param_byte();
		int k;
		k = $urandom_range(0, 19);
		if (k < 7)  return atcp_pkg::CH_COMMA;
		if (k < 15) return 8'($urandom_range(8'h30, 8'h7A));
		if (k == 15) return atcp_pkg::CH_NUL;
		if (k == 16) return atcp_pkg::CH_LF;
		return 8'($urandom_range(0, 255));
	endfunction

	// a mostly well-formed command line with random content
	task automatic send_random_command();
		logic [7:0]  cmd[$];
		logic [15:0] nm;
		int          n;
		int          pick;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 5);
			repeat (n)
				case ($urandom_range(0, 2))
					0:       cmd.push_back(atcp_pkg::CH_A);
					1:       cmd.push_back(atcp_pkg::CH_T);
					default: cmd.push_back(atcp_pkg::CH_PLUS);
				endcase
		end else begin
			cmd.push_back(atcp_pkg::CH_A);
			cmd.push_back(atcp_pkg::CH_T);
			cmd.push_back(atcp_pkg::CH_PLUS);
		end
		if ($urandom_range(0, 3) != 0) begin
			nm = CMD_NAMES[$urandom_range(0, 37)];
			cmd.push_back(nm[15:8]);
			cmd.push_back(nm[7:0]);
		end else begin
			cmd.push_back(8'($urandom_range(0, 255)));
			cmd.push_back(8'($urandom_range(0, 255)));
		end
		pick = $urandom_range(0, 19);
		if (pick >= 8 && pick < 17) begin
			cmd.push_back(atcp_pkg::CH_EQ);
			n = ($urandom_range(0, 29) == 0) ? $urandom_range(55, 75) : $urandom_range(0, 12);
			repeat (n) cmd.push_back(param_byte());
		end else if (pick >= 17) begin
			cmd.push_back(8'($urandom_range(0, 255)));
		end
		cmd.push_back(atcp_pkg::CH_SEMI);
		foreach (cmd[i]) push_byte(cmd[i]);
	endtask

	// stimulus
	initial begin
		logic [7:0] b;
		int         start_bytes;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		typed_pending = 1'b0;
		errors        = 0;
		bytes_in      = 0;
		results       = 0;
		burst_left    = 0;
		per_status    = '{0, 0, 0, 0};
		drop_line();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed lines: extremes, every status and the prefix quirks
		add_line("AT+SD;", 0, "x", 1, atcp_pkg::ST_OK, 0);
		add_line("AT+DB;", 0, "x", 1, atcp_pkg::ST_OK, 37);
		add_line("AT+ZZ;", 0, "x", 1, atcp_pkg::ST_UNKNOWN, 0);
		add_line("AT+sd;", 0, "x", 1, atcp_pkg::ST_UNKNOWN, 0);
		add_line("AT+SDx;", 0, "x", 1, atcp_pkg::ST_PARAM, 0);
		add_line("ATT+SD;", 0, "x", 1, atcp_pkg::ST_UNKNOWN, 0);
		add_line("AT+GX=1,2;", 0, "x", 0, atcp_pkg::ST_OK, 0);
		add_line("AT+gX=;", 0, "x", 0, atcp_pkg::ST_OK, 0);
		add_line("AT+S~D\n=,,a,,b;", 0, "x", 0, atcp_pkg::ST_OK, 0);
		add_line("AAT+GX;", 0, "x", 0, atcp_pkg::ST_OK, 0);
		add_line("AT;", 0, "x", 0, atcp_pkg::ST_OK, 0);
		add_line("A\nT+SD;", 0, "x", 0, atcp_pkg::ST_OK, 0);
		add_line("^AT+dB=^;", 0, "x", 0, atcp_pkg::ST_OK, 0);
		add_line("ATAT+FW=x;", 0, "x", 0, atcp_pkg::ST_OK, 0);
		add_line("AT+;", 0, "x", 0, atcp_pkg::ST_OK, 0);
		add_line("AT+DT=~1\n,~2,3;", 0, "x", 0, atcp_pkg::ST_OK, 0);
		// most tokens that fit: ';' lands on the last buffer position
		add_line("AT+SD=;", 57, atcp_pkg::CH_COMMA, 0, atcp_pkg::ST_OK, 0);
		// buffer exactly full before ';', then well past full
		add_line("AT+SD=;", 58, "x", 1, atcp_pkg::ST_OVERFLOW, 0);
		add_line("AT+EW=;", 80, "y", 1, atcp_pkg::ST_OVERFLOW, 0);
		// prefix runs out of buffer on an 'A' and on a '+'
		add_line("AA", 63, atcp_pkg::CH_A, 0, atcp_pkg::ST_OK, 0);
		add_line("AT+", 62, atcp_pkg::CH_A, 0, atcp_pkg::ST_OK, 0);
		add_line("AT+FW;", 0, "x", 1, atcp_pkg::ST_OK, 35);

		foreach (plan[n]) begin
			if (plan[n].typed) begin
				typed_reply   = plan[n].want;
				typed_pending = 1'b1;
			end
			for (int i = 0; i < plan[n].txt.len(); i++) begin
				if (i == plan[n].txt.len() - 1)
					for (int k = 0; k < plan[n].pad; k++)
						push_byte((plan[n].pad_ch == atcp_pkg::CH_COMMA && k % 2 == 1)
						          ? 8'("a") : plan[n].pad_ch);
				b = plan[n].txt[i];
				if (b == "~") b = atcp_pkg::CH_NUL;
				else if (b == "^") b = 8'hFF;
				push_byte(b);
			end
		end

		// pause until the block has delivered everything
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (exp_q.size() != 0) @(negedge clk);

		// random lines with some noise between them
		start_bytes = bytes_in;
		while (bytes_in - start_bytes < 200) begin
			if ($urandom_range(0, 6) == 0)
				repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
			send_random_command();
		end

		// drain and let the block settle
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (exp_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("summary: %0d bytes accepted, %0d results checked", bytes_in, results);
		$display("summary: ok %0d, unknown %0d, parameter error %0d, overflow %0d",
		         per_status[atcp_pkg::ST_OK], per_status[atcp_pkg::ST_UNKNOWN],
		         per_status[atcp_pkg::ST_PARAM], per_status[atcp_pkg::ST_OVERFLOW]);
		if (errors == 0)
			$display("at_command_parser_tb: done, clean");
		else
			$display("at_command_parser_tb: done, errors");
		$finish;
	end

endmodule
